FILE: design/homogeneous_point_transform_core_macros.svh
// Assertion macros shared by the point transform RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_CORE_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HPT_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point transform assertion failed");

// Next-cycle implication, checked outside reset.
`define HPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point transform assertion failed");

`endif

FILE: design/hpt_pkg.sv
// Package for the homogeneous point transform core.
// Holds the request, result and work item types and fixed arithmetic widths.
// No dependencies.
`default_nettype none

package hpt_pkg;

    localparam int ENTRY_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_W      = 48;   // rounded product, Q32.16
    localparam int ACC_W       = 50;   // signed dot product sum
    localparam int MAG_W       = 49;   // magnitude of a sum
    localparam int QUO_W       = 33;   // quotient bits with one rounding bit
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_POINT    = 2'd1;
    localparam logic [1:0] OP_DIR      = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]                operation;
        logic [3:0]                entry_index;
        logic signed [ENTRY_W-1:0] entry_value;
        logic signed [ENTRY_W-1:0] vec_x;
        logic signed [ENTRY_W-1:0] vec_y;
        logic signed [ENTRY_W-1:0] vec_z;
    } hpt_request_t;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] out_x;
        logic signed [ENTRY_W-1:0] out_y;
        logic signed [ENTRY_W-1:0] out_z;
        logic                      zero_w;
        logic                      saturated;
    } hpt_result_t;

    // prod[column][row] holds a rounded product, bias[column] the bottom row entry
    // (already cleared for direction mode, except for the w column).
    typedef struct packed {
        logic [3:0][2:0][PROD_W-1:0] prod;
        logic [3:0][ENTRY_W-1:0]     bias;
    } hpt_work_t;

endpackage

`default_nettype wire

FILE: design/hpt_front.sv
// Front end of the point transform: matrix storage, request intake and products.
// Depends on hpt_pkg.
`default_nettype none

module hpt_front
    import hpt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         request_valid,
    output logic              request_stall,
    input  wire hpt_request_t request,
    input  wire logic         queue_full,
    output logic              push,
    output hpt_work_t         push_data
);

    logic [15:0][ENTRY_W-1:0]    matrix_reg;
    logic                        prod_valid_reg;
    logic [3:0][2:0][63:0]       prod_reg;
    logic [3:0][ENTRY_W-1:0]     bias_reg;
    logic [2:0][ENTRY_W-1:0]     vec;
    logic                        hold;
    logic                        accept;
    logic                        is_transform;

    assign hold          = prod_valid_reg && queue_full;
    assign request_stall = hold;
    assign accept        = request_valid && !hold;
    assign is_transform  = (request.operation == OP_POINT) || (request.operation == OP_DIR);
    assign vec           = {request.vec_z, request.vec_y, request.vec_x};

    // Matrix entries; reset gives the identity matrix.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                matrix_reg[i] <= (i % 5 == 0) ? ENTRY_W'(32'h0001_0000) : '0;
            end
        end
        else if (accept && request.operation == OP_LOAD)
        begin
            matrix_reg[request.entry_index] <= request.entry_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            prod_valid_reg <= accept && is_transform;
        end
    end

    // Products are taken from the matrix as it stands when the request is accepted.
    always_ff @(posedge clk)
    begin
        if (!hold && accept && is_transform)
        begin
            for (int c = 0; c < 4; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    prod_reg[c][r] <= $signed(vec[r]) * $signed(matrix_reg[4'(r * 4 + c)]);
                end
                bias_reg[c] <= (c == 3 || request.operation == OP_POINT)
                               ? matrix_reg[4'(12 + c)] : '0;
            end
        end
    end

    // Round half up to Q32.16: add one half, then drop the low fraction bits.
    always_comb
    begin
        logic [63:0] rnd;
        rnd = '0;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rnd = prod_reg[c][r] + 64'd32768;
                push_data.prod[c][r] = rnd[FRAC_BITS +: PROD_W];
            end
        end
        push_data.bias = bias_reg;
    end

    assign push = prod_valid_reg && !queue_full;

endmodule

`default_nettype wire

FILE: design/hpt_queue.sv
// Short first-in first-out queue of work items between the front and back ends.
// Depends on hpt_pkg.
`default_nettype none

module hpt_queue
    import hpt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire hpt_work_t push_data,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output hpt_work_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hpt_work_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/hpt_div_lane.sv
// Pipelined restoring divider for one component, one quotient bit per stage.
// Depends on hpt_pkg.
`default_nettype none

module hpt_div_lane
    import hpt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [MAG_W-1:0] in_num,
    input  wire logic [MAG_W-1:0] in_den,
    input  wire logic             in_neg,
    output logic [QUO_W-1:0]      out_quo,
    output logic                  out_ovf,
    output logic                  out_neg
);

    logic [MAG_W-1:0]     rem_reg  [QUO_W+1];
    logic [MAG_W-1:0]     den_reg  [QUO_W+1];
    logic [FRAC_BITS-1:0] low_reg  [QUO_W+1];
    logic [QUO_W-1:0]     quo_reg  [QUO_W+1];
    logic                 ovf_reg  [QUO_W+1];
    logic                 neg_reg  [QUO_W+1];

    // The integer quotient must stay below 2^16; the starting remainder is then
    // below the divisor and the remaining bits come out one per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= in_num >> FRAC_BITS;
            den_reg[0] <= in_den;
            low_reg[0] <= in_num[FRAC_BITS-1:0];
            quo_reg[0] <= '0;
            ovf_reg[0] <= {{FRAC_BITS{1'b0}}, in_num} >= ({{FRAC_BITS{1'b0}}, in_den}
                          << FRAC_BITS);
            neg_reg[0] <= in_neg;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           ge;

        assign trial = {rem_reg[k], low_reg[k][FRAC_BITS-1]};
        assign diff  = trial - {1'b0, den_reg[k]};
        assign ge    = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                den_reg[k+1] <= den_reg[k];
                low_reg[k+1] <= low_reg[k] << 1;
                quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], ge};
                ovf_reg[k+1] <= ovf_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    assign out_quo = quo_reg[QUO_W];
    assign out_ovf = ovf_reg[QUO_W];
    assign out_neg = neg_reg[QUO_W];

endmodule

`default_nettype wire

FILE: design/hpt_back.sv
// Back end of the point transform: sums, divide by w, rounding and saturation.
// Depends on hpt_pkg and hpt_div_lane.
`default_nettype none

module hpt_back
    import hpt_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      head_valid,
    input  wire hpt_work_t head,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_stall,
    output hpt_result_t    result
);

    localparam int SAT_BITS = (WORD_BITS > 32) ? 32 : WORD_BITS;
    localparam int LANE_LAT = QUO_W + 1;
    localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (SAT_BITS - 1);
    localparam logic [QUO_W-1:0] POS_LIM = NEG_LIM - QUO_W'(1);

    logic                    advance;
    logic                    sum_valid_reg;
    logic signed [ACC_W-1:0] sum_reg  [4];
    logic signed [ACC_W-1:0] sum_next [4];
    logic                    mag_valid_reg;
    logic [MAG_W-1:0]        num_reg  [3];
    logic [MAG_W-1:0]        den_reg;
    logic [2:0]              neg_reg;
    logic                    zero_reg;
    logic [LANE_LAT-1:0]     vld_reg;
    logic [LANE_LAT-1:0]     zero_pipe_reg;
    logic [QUO_W-1:0]        lane_quo [3];
    logic [2:0]              lane_ovf;
    logic [2:0]              lane_neg;
    logic                    result_valid_reg;
    hpt_result_t             result_reg;
    hpt_result_t             result_next;

    assign advance = !(result_valid_reg && result_stall);
    assign pop     = head_valid && advance;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum_next[c] = ACC_W'($signed(head.prod[c][0])) + ACC_W'($signed(head.prod[c][1]))
                        + ACC_W'($signed(head.prod[c][2])) + ACC_W'($signed(head.bias[c]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg    <= 1'b0;
            mag_valid_reg    <= 1'b0;
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_valid_reg    <= pop;
            mag_valid_reg    <= sum_valid_reg;
            vld_reg          <= {vld_reg[LANE_LAT-2:0], mag_valid_reg};
            result_valid_reg <= vld_reg[LANE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
            for (int c = 0; c < 3; c++)
            begin
                num_reg[c] <= sum_reg[c][ACC_W-1] ? MAG_W'(-sum_reg[c]) : MAG_W'(sum_reg[c]);
                neg_reg[c] <= sum_reg[c][ACC_W-1] ^ sum_reg[3][ACC_W-1];
            end
            den_reg       <= sum_reg[3][ACC_W-1] ? MAG_W'(-sum_reg[3]) : MAG_W'(sum_reg[3]);
            zero_reg      <= (sum_reg[3] == '0);
            zero_pipe_reg <= {zero_pipe_reg[LANE_LAT-2:0], zero_reg};
            result_reg    <= result_next;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        hpt_div_lane u_div_lane (
            .clk     (clk),
            .en      (advance),
            .in_num  (num_reg[c]),
            .in_den  (den_reg),
            .in_neg  (neg_reg[c]),
            .out_quo (lane_quo[c]),
            .out_ovf (lane_ovf[c]),
            .out_neg (lane_neg[c])
        );
    end

    // Round the quotient to nearest, apply the sign and clamp to range; a zero w gives zeros.
    always_comb
    begin
        logic [QUO_W:0]         quo_p1;
        logic [QUO_W-1:0]       mag;
        logic [QUO_W-1:0]       lim;
        logic [QUO_W-1:0]       val;
        logic [QUO_W-1:0]       neg_val;
        logic                   big;
        logic [2:0][ENTRY_W-1:0] comp;
        logic                   sat;

        quo_p1  = '0;
        mag     = '0;
        lim     = '0;
        val     = '0;
        neg_val = '0;
        big     = 1'b0;
        comp    = '0;
        sat     = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            quo_p1  = {1'b0, lane_quo[c]} + 1'b1;
            mag     = quo_p1[QUO_W:1];
            lim     = lane_neg[c] ? NEG_LIM : POS_LIM;
            big     = lane_ovf[c] || (mag > lim);
            val     = big ? lim : mag;
            neg_val = -val;
            comp[c] = lane_neg[c] ? neg_val[ENTRY_W-1:0] : val[ENTRY_W-1:0];
            sat     = sat || big;
        end
        if (zero_pipe_reg[LANE_LAT-1])
        begin
            result_next.out_x     = '0;
            result_next.out_y     = '0;
            result_next.out_z     = '0;
            result_next.zero_w    = 1'b1;
            result_next.saturated = 1'b0;
        end
        else
        begin
            result_next.out_x     = comp[0];
            result_next.out_y     = comp[1];
            result_next.out_z     = comp[2];
            result_next.zero_w    = 1'b0;
            result_next.saturated = sat;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: design/homogeneous_point_transform_core.sv
// Homogeneous point transform core with perspective divide (top level).
// Depends on hpt_pkg, hpt_front, hpt_queue, hpt_back and the assertion macro header.
//
// Usage:
// The request channel (request_valid, request_stall, request) carries either a
// matrix entry load or a point or direction transform. A request is taken at a
// rising edge with request_valid high and request_stall low. Loads take effect at
// once and give no result; transforms use the matrix as it stood when taken.
// The result channel (result_valid, result_stall, result) delivers one result per
// transform in request order; the receiver holds result_stall high to pause it.
// Throughput is one request per cycle while request_stall stays low. On the way to
// result_valid the product register loads at the accepting edge, then come
// one queue stage, two sum and sign stages, a 34-stage pipelined divider (33
// quotient bits plus a range check) and the output register. The divider depth
// makes up most of this path.
// A stall on a valid result freezes the whole back end; the two-entry queue then
// fills and request_stall rises once the product stage cannot drain.
// Reset loads the identity matrix and empties the pipeline.
`default_nettype none

`include "homogeneous_point_transform_core_macros.svh"

module homogeneous_point_transform_core
    import hpt_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         request_valid,
    output logic              request_stall,
    input  wire hpt_request_t request,
    output logic              result_valid,
    input  wire logic         result_stall,
    output hpt_result_t       result
);

    logic      queue_push;
    logic      queue_full;
    logic      queue_pop;
    logic      queue_head_valid;
    hpt_work_t queue_push_data;
    hpt_work_t queue_head;

    // Front end: stores the matrix and forms the twelve products of a transform.
    hpt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .queue_full    (queue_full),
        .push          (queue_push),
        .push_data     (queue_push_data)
    );

    // Queue decouples product formation from the long divide pipeline.
    hpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_data  (queue_push_data),
        .full       (queue_full),
        .pop        (queue_pop),
        .head_valid (queue_head_valid),
        .head       (queue_head)
    );

    // Back end: dot product sums, divide by w, rounding and saturation.
    hpt_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (queue_head_valid),
        .head         (queue_head),
        .pop          (queue_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // A zero w result carries zero components and never reports saturation.
    `HPT_ASSERT_IMPLY(a_zero_w_clean, result_valid && result.zero_w, result.out_x == '0 && result.out_y == '0 && result.out_z == '0 && !result.saturated)
    // The front end only holds off requests while the queue is full.
    `HPT_ASSERT_IMPLY(a_stall_needs_full, request_stall, queue_full)
    // A full queue stays full until the back end takes an item.
    `HPT_ASSERT_NEXT(a_full_holds, queue_full && !queue_pop, queue_full)

endmodule

`default_nettype wire
